FILE: rtl/lru_pkg.sv
// shared constants and controller/datapath interface types for the lru page replacement core
`timescale 1ns / 1ps

package lru_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 32;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = FRAME_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } lru_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture an accepted request
    logic eval;    // search frames and register the decision
    logic commit;  // update frames and load the output register
  } lru_cmd_t;

endpackage

FILE: rtl/lru_ctrl.sv
// controller state machine: request sequencing and output register handshake
`timescale 1ns / 1ps

module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lru_cmd_t cmd_o
);

  lru_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       commit_ok;
  logic       accept;

  // commit only when the output register is free or being emptied now
  assign commit_ok = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_ok) state_d = accept ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE) || commit_ok;
    cmd_o.load   = accept;
    cmd_o.eval   = (state_q == ST_EVAL);
    cmd_o.commit = commit_ok;
    if (commit_ok) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/lru_datapath.sv
// datapath: frame table, recency ranks, fault counter and output register
`timescale 1ns / 1ps

module lru_datapath
  import lru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lru_cmd_t             cmd_i,
  input  logic [PAGE_BITS-1:0] requested_page_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 hit_o,
  output logic [FRAME_W-1:0]   frame_used_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    frame_valid_q;
  logic [RANK_W-1:0]    rank_q [FRAMES];
  logic [FAULT_W-1:0]   fault_q;
  logic [CFG_W-1:0]     active_q;
  logic [PAGE_BITS-1:0] page_q;

  // decision registered at the end of evaluation
  logic                 dec_hit_q;
  logic                 dec_evict_q;
  logic [FRAME_W-1:0]   dec_frame_q;

  logic [CNT_W-1:0]     eff;
  logic                 found, empty;
  logic [FRAME_W-1:0]   hit_idx, empty_idx, lru_idx;
  logic [RANK_W-1:0]    min_rank;
  logic [RANK_W-1:0]    old_rank;
  logic [FAULT_W-1:0]   fault_next;

  // clamp the frame count into 1..FRAMES
  always_comb begin
    if (active_q == '0) begin
      eff = CNT_W'(1);
    end else if ({{(32-CFG_W){1'b0}}, active_q} > 32'(FRAMES)) begin
      eff = CNT_W'(FRAMES);
    end else begin
      eff = CNT_W'(active_q);
    end
  end

  // parallel search over the active frames, lowest index wins
  always_comb begin
    found     = 1'b0;
    empty     = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    lru_idx   = '0;
    min_rank  = rank_q[0];
    for (int i = 0; i < FRAMES; i++) begin
      if (CNT_W'(i) < eff) begin
        if (!found && frame_valid_q[i] && frame_page_q[i] == page_q) begin
          found   = 1'b1;
          hit_idx = FRAME_W'(i);
        end
        if (!empty && !frame_valid_q[i]) begin
          empty     = 1'b1;
          empty_idx = FRAME_W'(i);
        end
        if (i > 0 && rank_q[i] < min_rank) begin
          min_rank = rank_q[i];
          lru_idx  = FRAME_W'(i);
        end
      end
    end
  end

  assign old_rank   = rank_q[dec_frame_q];
  assign fault_next = (fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) page_q <= requested_page_i;
    if (cmd_i.eval) begin
      dec_hit_q   <= found;
      dec_evict_q <= !found && !empty;
      dec_frame_q <= found ? hit_idx : (empty ? empty_idx : lru_idx);
    end
    if (cmd_i.commit) begin
      if (!dec_hit_q) frame_page_q[dec_frame_q] <= page_q;
      hit_o           <= dec_hit_q;
      frame_used_o    <= dec_frame_q;
      evicted_valid_o <= dec_evict_q;
      evicted_page_o  <= dec_evict_q ? frame_page_q[dec_frame_q] : '0;
      fault_total_o   <= dec_hit_q ? fault_q : fault_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      fault_q       <= '0;
      active_q      <= CFG_RESET;
      for (int i = 0; i < FRAMES; i++) rank_q[i] <= RANK_W'(i);
    end else if (cfg_we_i) begin
      active_q      <= cfg_wdata_i;
      frame_valid_q <= '0;
      for (int i = 0; i < FRAMES; i++) rank_q[i] <= RANK_W'(i);
    end else if (cmd_i.commit) begin
      // touched frame goes to the top, ranks above it shift down
      for (int i = 0; i < FRAMES; i++) begin
        if (FRAME_W'(i) == dec_frame_q) begin
          rank_q[i] <= RANK_W'(FRAMES - 1);
        end else if (rank_q[i] > old_rank) begin
          rank_q[i] <= rank_q[i] - RANK_W'(1);
        end
      end
      if (!dec_hit_q) begin
        frame_valid_q[dec_frame_q] <= 1'b1;
        fault_q                    <= fault_next;
      end
    end
  end

endmodule

FILE: rtl/lru_page_replacement_core.sv
// top level of the fully associative lru page replacement core
//
//  channel   direction  handshake                payload
//  request   in         in_valid_i / in_ready_o   requested_page_i
//  result    out        out_valid_o / out_ready_i hit_o frame_used_o evicted_valid_o
//                                                  evicted_page_o fault_total_o
//  config    in         cfg_we_i                 cfg_wdata_i (active frame count)
//
// a request is first evaluated, searching all frames in parallel and registering the
// decision; commit then updates frames and ranks and loads the output register.
// reset clears all frames, ranks equal the frame index, fault count is zero.
// while a result waits in the output register the next request is still accepted and
// evaluated; it holds in its commit cycle until the output register is freed.
`timescale 1ns / 1ps

module lru_page_replacement_core
  import lru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_BITS-1:0] requested_page_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [FRAME_W-1:0]   frame_used_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lru_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .requested_page_i (requested_page_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .hit_o            (hit_o),
    .frame_used_o     (frame_used_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .fault_total_o    (fault_total_o)
  );

  // an accepted request is evaluated in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.eval)
    else $error("accepted request not evaluated");

  // no new request while a decision is being formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> !in_ready_o)
    else $error("request accepted during evaluation");

  // a commit always leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit without result");

  // a hit never reports an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> !evicted_valid_o)
    else $error("eviction reported on hit");

endmodule
